/* rtl/core/coupled_vdp_derivative_core_defines.svh */
// Assertion helpers; clk and arst_n are taken from the enclosing module.
`ifndef COUPLED_VDP_DERIVATIVE_CORE_DEFINES_SVH
`define COUPLED_VDP_DERIVATIVE_CORE_DEFINES_SVH

// same-cycle implication
`define CVD_ASSERT_NOW(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication
`define CVD_ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

/* rtl/core/cvd_pkg.sv */
package cvd_pkg;

	localparam int FRAC_BITS    = 24;
	localparam int CORDIC_STEPS = 16;
	localparam int Q_W          = 32;

	typedef logic signed [Q_W-1:0] q_t;

	localparam int PROD_W  = 2 * Q_W;
	localparam int RPROD_W = 2 * Q_W + 1;
	localparam int SUM_W   = 2 * Q_W + 4 - FRAC_BITS;

	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [RPROD_W-1:0] rprod_t;
	typedef logic signed [SUM_W-1:0]   acc_t;

	localparam q_t   Q_ONE = q_t'(33'sd1 <<< FRAC_BITS);
	localparam acc_t Q_MAX = acc_t'(64'sh7FFFFFFF);
	localparam acc_t Q_MIN = acc_t'(-64'sh80000000);

	// configuration registers
	localparam int N_REGS = 7;
	localparam int IDX_W  = $clog2(N_REGS);
	localparam int ADDR_W = IDX_W + 2;

	localparam logic [IDX_W-1:0] REG_DETUNE_1   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_DETUNE_2   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_DETUNE_3   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_COUPLING   = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_DRIVE_FREQ = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_DRIVE_AMP  = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_NONLIN     = IDX_W'(6);

	typedef struct packed {
		q_t detune_1;
		q_t detune_2;
		q_t detune_3;
		q_t coupling;
		q_t drive_freq;
		q_t drive_amp;
		q_t nonlin_gain;
	} cfg_t;

	// angle reduction: A + (P << RED_SH) is positive, then restoring steps
	localparam int U_W    = 66;
	localparam int RED_SH = 45 - FRAC_BITS;
	localparam int RED_N  = RED_SH + 2;
	localparam logic [63:0]    TWO_PI_Q60 = 64'h6487ED5110B4611A;
	localparam logic [U_W-1:0] RED_P      = U_W'(TWO_PI_Q60 >> (44 - FRAC_BITS));
	localparam logic [U_W-1:0] RED_OFF    = RED_P << RED_SH;
	localparam int ZSHR = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
	localparam int ZSHL = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;

	localparam int Z_W  = 35;
	localparam int CX_W = 34;
	typedef logic signed [Z_W-1:0]  ang_t;
	typedef logic signed [CX_W-1:0] cx_t;

	localparam ang_t PI_Q30      = ang_t'(64'sh0C90FDAA2);
	localparam ang_t HALF_PI_Q30 = ang_t'(64'sh06487ED51);
	localparam ang_t TWO_PI_Q30  = ang_t'(64'sh1921FB544);
	localparam cx_t  CX_INIT     = cx_t'(64'sh26DD3B6A);

	localparam int N_CS = (CORDIC_STEPS < 31) ? CORDIC_STEPS : 31;

	// pipeline depth
	localparam int ANG_LAT  = RED_N + 3;
	localparam int CORD_LAT = N_CS + 1;
	localparam int OSC_LAT  = 4;
	localparam int LAT      = ANG_LAT + CORD_LAT + 2;
	localparam int DLY      = LAT - 1 - OSC_LAT;

	typedef struct packed {
		acc_t part_1;
		acc_t part_2;
		acc_t part_3;
		q_t   vel_1;
		q_t   vel_2;
		q_t   vel_3;
	} osc_res_t;

	function automatic q_t sat_q(input acc_t v);
		q_t r;
		if (v > Q_MAX) r = q_t'(Q_MAX);
		else if (v < Q_MIN) r = q_t'(Q_MIN);
		else r = q_t'(v);
		return r;
	endfunction

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h3243F6A8;
			1: r = 32'h1DAC6705;
			2: r = 32'h0FADBAFC;
			3: r = 32'h07F56EA6;
			4: r = 32'h03FEAB76;
			5: r = 32'h01FFD55B;
			6: r = 32'h00FFFAAA;
			7: r = 32'h007FFF55;
			8: r = 32'h003FFFEA;
			9: r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			24: r = 32'h0000003F;
			25: r = 32'h0000001F;
			26: r = 32'h0000000F;
			27: r = 32'h00000008;
			28: r = 32'h00000004;
			29: r = 32'h00000002;
			30: r = 32'h00000001;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/cvd_if.sv */
interface cvd_item_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_1;
	logic signed [31:0] vel_1;
	logic signed [31:0] pos_2;
	logic signed [31:0] vel_2;
	logic signed [31:0] pos_3;
	logic signed [31:0] vel_3;
	logic        [31:0] time_now;

	modport source(output valid, pos_1, vel_1, pos_2, vel_2, pos_3, vel_3, time_now,
		input ready);
	modport sink(input valid, pos_1, vel_1, pos_2, vel_2, pos_3, vel_3, time_now,
		output ready);
endinterface

interface cvd_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] dpos_1;
	logic signed [31:0] dvel_1;
	logic signed [31:0] dpos_2;
	logic signed [31:0] dvel_2;
	logic signed [31:0] dpos_3;
	logic signed [31:0] dvel_3;

	modport source(output valid, dpos_1, dvel_1, dpos_2, dvel_2, dpos_3, dvel_3,
		input ready);
	modport sink(input valid, dpos_1, dvel_1, dpos_2, dvel_2, dpos_3, dvel_3,
		output ready);
endinterface

/* rtl/core/cvd_regs.sv */
module cvd_regs import cvd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic             wr;
	logic [IDX_W-1:0] idx;
	cfg_t             cfg_q;

	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detune_1    <= '0;
			cfg_q.detune_2    <= '0;
			cfg_q.detune_3    <= '0;
			cfg_q.coupling    <= '0;
			cfg_q.drive_freq  <= Q_ONE;
			cfg_q.drive_amp   <= '0;
			cfg_q.nonlin_gain <= Q_ONE;
		end else if (wr) begin
			unique case (idx)
				REG_DETUNE_1:   cfg_q.detune_1    <= pwdata;
				REG_DETUNE_2:   cfg_q.detune_2    <= pwdata;
				REG_DETUNE_3:   cfg_q.detune_3    <= pwdata;
				REG_COUPLING:   cfg_q.coupling    <= pwdata;
				REG_DRIVE_FREQ: cfg_q.drive_freq  <= pwdata;
				REG_DRIVE_AMP:  cfg_q.drive_amp   <= pwdata;
				REG_NONLIN:     cfg_q.nonlin_gain <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DETUNE_1:   prdata = cfg_q.detune_1;
			REG_DETUNE_2:   prdata = cfg_q.detune_2;
			REG_DETUNE_3:   prdata = cfg_q.detune_3;
			REG_COUPLING:   prdata = cfg_q.coupling;
			REG_DRIVE_FREQ: prdata = cfg_q.drive_freq;
			REG_DRIVE_AMP:  prdata = cfg_q.drive_amp;
			REG_NONLIN:     prdata = cfg_q.nonlin_gain;
			default:        prdata = '0;
		endcase
	end

endmodule

/* rtl/core/cvd_angle.sv */
module cvd_angle import cvd_pkg::*; (
	input  logic        clk,
	input  logic        adv,
	input  q_t          freq,
	input  logic [31:0] t,
	output ang_t        z,
	output logic        neg
);

	prod_t          ang_s1;
	logic [U_W-1:0] rem_s [RED_N+1];
	ang_t           z_sf;
	logic           neg_sf;
	ang_t           z0, z1, z2;
	logic           n2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1   <= freq * $signed({1'b0, t});
			rem_s[0] <= $unsigned(U_W'(ang_s1)) + RED_OFF;
		end
	end

	// one restoring step per stage, largest multiple first
	for (genvar j = 0; j < RED_N; j++) begin : g_red
		localparam logic [U_W-1:0] PK = RED_P << (RED_N - 1 - j);
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1] <= (rem_s[j] >= PK) ? rem_s[j] - PK : rem_s[j];
			end
		end
	end

	// to Q.30, fold into [-pi/2, pi/2]
	always_comb begin
		z0 = $signed(Z_W'((rem_s[RED_N] >> ZSHR) << ZSHL));
		z1 = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 : z0;
		n2 = 1'b0;
		if (z1 > HALF_PI_Q30) begin
			z2 = PI_Q30 - z1;
			n2 = 1'b1;
		end else if (z1 < -HALF_PI_Q30) begin
			z2 = -PI_Q30 - z1;
			n2 = 1'b1;
		end else begin
			z2 = z1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_sf   <= z2;
			neg_sf <= n2;
		end
	end

	assign z   = z_sf;
	assign neg = neg_sf;

endmodule

/* rtl/core/cvd_cordic.sv */
module cvd_cordic import cvd_pkg::*; (
	input  logic clk,
	input  logic adv,
	input  ang_t z,
	input  logic neg,
	output q_t   cosq
);

	cx_t  x_s [N_CS];
	cx_t  y_s [N_CS];
	ang_t z_s [N_CS];
	logic n_s [N_CS];
	cx_t  xn;
	q_t   cos_sf;

	for (genvar j = 0; j < N_CS; j++) begin : g_step
		localparam ang_t ATAN_J = ang_t'(atan_q30(j));
		cx_t  xp, yp;
		ang_t zp;
		logic np;
		if (j == 0) begin : g_first
			assign xp = CX_INIT;
			assign yp = '0;
			assign zp = z;
			assign np = neg;
		end else begin : g_next
			assign xp = x_s[j-1];
			assign yp = y_s[j-1];
			assign zp = z_s[j-1];
			assign np = n_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (zp >= 0) begin
					x_s[j] <= xp - (yp >>> j);
					y_s[j] <= yp + (xp >>> j);
					z_s[j] <= zp - ATAN_J;
				end else begin
					x_s[j] <= xp + (yp >>> j);
					y_s[j] <= yp - (xp >>> j);
					z_s[j] <= zp + ATAN_J;
				end
				n_s[j] <= np;
			end
		end
	end

	assign xn = n_s[N_CS-1] ? -x_s[N_CS-1] : x_s[N_CS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_sf <= q_t'(xn >>> (30 - FRAC_BITS));
		end
	end

	assign cosq = cos_sf;

endmodule

/* rtl/core/cvd_osc.sv */
module cvd_osc import cvd_pkg::*; (
	input  logic     clk,
	input  logic     adv,
	input  cfg_t     cfg,
	input  q_t       pos_1,
	input  q_t       vel_1,
	input  q_t       pos_2,
	input  q_t       vel_2,
	input  q_t       pos_3,
	input  q_t       vel_3,
	output osc_res_t res
);

	q_t               pos [3];
	q_t               vel [3];
	q_t               det [3];
	logic signed [32:0] rg [3];

	prod_t  xx_s1 [3];
	rprod_t rp_s1 [3];
	prod_t  cp_s1 [3];
	q_t     v_s1  [3];

	acc_t   cf    [3];
	acc_t   ct    [3];
	q_t     g_s2  [3];
	acc_t   pre_s2 [3];
	q_t     v_s2  [3];

	prod_t  dp_s3 [3];
	acc_t   pre_s3 [3];
	q_t     v_s3  [3];

	acc_t   part_s4 [3];
	q_t     v_s4    [3];

	assign pos[0] = pos_1;
	assign pos[1] = pos_2;
	assign pos[2] = pos_3;
	assign vel[0] = vel_1;
	assign vel[1] = vel_2;
	assign vel[2] = vel_3;
	assign det[0] = cfg.detune_1;
	assign det[1] = cfg.detune_2;
	assign det[2] = cfg.detune_3;

	for (genvar k = 0; k < 3; k++) begin : g_cf
		assign rg[k] = 33'(det[k]) + 33'(Q_ONE);
		assign cf[k] = acc_t'(cp_s1[k] >>> FRAC_BITS);
	end

	// diffusive chain coupling
	assign ct[0] = cf[0] - cf[1];
	assign ct[1] = (cf[1] <<< 1) - cf[0] - cf[2];
	assign ct[2] = cf[2] - cf[1];

	for (genvar k = 0; k < 3; k++) begin : g_lane
		always_ff @(posedge clk) begin
			if (adv) begin
				xx_s1[k] <= pos[k] * pos[k];
				rp_s1[k] <= rg[k] * pos[k];
				cp_s1[k] <= cfg.coupling * pos[k];
				v_s1[k]  <= vel[k];

				g_s2[k]   <= sat_q(acc_t'(cfg.nonlin_gain) - acc_t'(xx_s1[k] >>> FRAC_BITS));
				pre_s2[k] <= -acc_t'(rp_s1[k] >>> FRAC_BITS) - ct[k];
				v_s2[k]   <= v_s1[k];

				dp_s3[k]  <= g_s2[k] * v_s2[k];
				pre_s3[k] <= pre_s2[k];
				v_s3[k]   <= v_s2[k];

				part_s4[k] <= acc_t'(dp_s3[k] >>> FRAC_BITS) + pre_s3[k];
				v_s4[k]    <= v_s3[k];
			end
		end
	end

	assign res.part_1 = part_s4[0];
	assign res.part_2 = part_s4[1];
	assign res.part_3 = part_s4[2];
	assign res.vel_1  = v_s4[0];
	assign res.vel_2  = v_s4[1];
	assign res.vel_3  = v_s4[2];

endmodule

/* rtl/core/coupled_vdp_derivative_core.sv */
// Pipeline depth is set by the angle reduction and rotation stages (FRAC_BITS 24, 16 rotation steps).
// Throughput: one request per cycle; a stalled result holds the whole pipeline.
// Reset (arst_n low) empties the pipeline and returns the valid bits and configuration registers to their reset values.
`include "coupled_vdp_derivative_core_defines.svh"

module coupled_vdp_derivative_core import cvd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	cvd_item_if.sink          item,
	cvd_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t          cfg;
	logic [LAT-1:0] vld_q;
	ang_t          ang_z;
	logic          ang_neg;
	q_t            cosq;
	osc_res_t      osc_res;
	osc_res_t      dly_s [DLY];
	prod_t         drv_s;
	osc_res_t      last;
	acc_t          drvf;
	q_t            dvel_1_so, dvel_2_so, dvel_3_so;
	q_t            dpos_1_so, dpos_2_so, dpos_3_so;
	logic          adv;

	cvd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// all stages move together when the output register is free or taken
	assign adv        = !vld_q[LAT-1] || result.ready;
	assign item.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], item.valid};
		end
	end

	cvd_angle u_angle (
		.clk  (clk),
		.adv  (adv),
		.freq (cfg.drive_freq),
		.t    (item.time_now),
		.z    (ang_z),
		.neg  (ang_neg)
	);

	cvd_cordic u_cordic (
		.clk  (clk),
		.adv  (adv),
		.z    (ang_z),
		.neg  (ang_neg),
		.cosq (cosq)
	);

	cvd_osc u_osc (
		.clk   (clk),
		.adv   (adv),
		.cfg   (cfg),
		.pos_1 (item.pos_1),
		.vel_1 (item.vel_1),
		.pos_2 (item.pos_2),
		.vel_2 (item.vel_2),
		.pos_3 (item.pos_3),
		.vel_3 (item.vel_3),
		.res   (osc_res)
	);

	for (genvar j = 0; j < DLY; j++) begin : g_dly
		osc_res_t prev;
		if (j == 0) begin : g_first
			assign prev = osc_res;
		end else begin : g_next
			assign prev = dly_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dly_s[j] <= prev;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drv_s <= cfg.drive_amp * cosq;
		end
	end

	assign last = dly_s[DLY-1];
	assign drvf = acc_t'(drv_s >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (adv) begin
			dpos_1_so <= last.vel_1;
			dpos_2_so <= last.vel_2;
			dpos_3_so <= last.vel_3;
			dvel_1_so <= sat_q(last.part_1 + drvf);
			dvel_2_so <= sat_q(last.part_2 + drvf);
			dvel_3_so <= sat_q(last.part_3 + drvf);
		end
	end

	assign result.valid  = vld_q[LAT-1];
	assign result.dpos_1 = dpos_1_so;
	assign result.dpos_2 = dpos_2_so;
	assign result.dpos_3 = dpos_3_so;
	assign result.dvel_1 = dvel_1_so;
	assign result.dvel_2 = dvel_2_so;
	assign result.dvel_3 = dvel_3_so;

	`CVD_ASSERT_NEXT(a_req_enters, item.valid && item.ready, vld_q[0], "request lost at entry")
	`CVD_ASSERT_NOW(a_full_stall, (&vld_q) && !result.ready, !item.ready, "full pipe took request")
	`CVD_ASSERT_NEXT(a_cfg_freq, psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_DRIVE_FREQ, cfg.drive_freq == $past(pwdata), "drive_freq write lost")

endmodule
